// ----- rtl/core/string_to_integer_parser_macros.svh -----
// ---------------------------------------------------------------------------
// String-to-integer parser assertion macros
// Shorthand for the concurrent checks that the parser modules carry.
// ---------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define STIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stip assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define STIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stip assertion failed");

`endif

// ----- rtl/core/stip_pkg.sv -----
// ---------------------------------------------------------------------------
// String-to-integer parser package
// Character codes, radix constants, parse phases and digit decoding.
// ---------------------------------------------------------------------------
package stip_pkg;

  // Field widths.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned WGT_W   = 7;

  // Default saturation limit of the consumed-byte count.
  localparam longint unsigned MAX_CONSUMED_DEF = 64'd65535;

  // Radix values.
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;

  // Weight given to a byte that is no digit in any radix.
  localparam logic [WGT_W-1:0] NO_DIGIT = 7'd99;

  // Parse phase of the current string.
  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGNED = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  // Digit weight of a character: 0-9, then letters for 10..35.
  function automatic logic [WGT_W-1:0] digit_weight(input logic [CHAR_W-1:0] c);
    logic [WGT_W-1:0] w;
    w = NO_DIGIT;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      w = WGT_W'(c - CHAR_0);
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      w = WGT_W'(c - CHAR_LA) + 7'd10;
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      w = WGT_W'(c - CHAR_UA) + 7'd10;
    end
    return w;
  endfunction

  // ASCII whitespace: tab through carriage return, and space.
  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

endpackage

// ----- rtl/core/stip_if.sv -----
// ---------------------------------------------------------------------------
// String-to-integer parser channels
// Valid/ready interfaces for the character stream and the parse results.
// ---------------------------------------------------------------------------
interface stip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface stip_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] parsed_value;
  logic        [15:0] bytes_consumed;
  logic               bad_base;

  modport source (output valid, output parsed_value, output bytes_consumed,
                  output bad_base, input ready);
  modport sink   (input valid, input parsed_value, input bytes_consumed,
                  input bad_base, output ready);
endinterface

// ----- rtl/core/string_to_integer_parser.sv -----
// ---------------------------------------------------------------------------
// String-to-integer parser
// Parses a signed integer from a byte stream, strtol style, one byte a beat.
// ---------------------------------------------------------------------------
// The parser takes one character beat per clock and presents one result beat
// after each beat marked last_char, once it passes the input stage register
// into the result register. Throughput is one byte per cycle unless stalled,
// set by the combinational accumulator update (acc * base - digit). The
// radix is sampled from cfg_wr_data's register at the first byte of each
// string; a radix above 36 yields bad_base with value and count zero. The
// count of consumed bytes saturates at the smaller of MAX_CONSUMED and 65535.
// in_ch.ready drops only while a last beat waits behind an untaken result.
module string_to_integer_parser #(
  parameter longint unsigned MAX_CONSUMED = stip_pkg::MAX_CONSUMED_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [stip_pkg::BASE_W-1:0]   cfg_wr_data,
  stip_in_if.sink                       in_ch,
  stip_out_if.source                    out_ch
);
  import stip_pkg::*;

  `include "string_to_integer_parser_macros.svh"

  localparam logic [CNT_W-1:0] COUNT_CAP =
    CNT_W'((MAX_CONSUMED < 64'd65535) ? MAX_CONSUMED : 64'd65535);

  // Configuration register.
  logic [BASE_W-1:0]  cfg_base_r;

  // Input stage.
  logic               s1_valid_r;
  logic [CHAR_W-1:0]  s1_byte_r;
  logic               s1_last_r;
  logic               s1_adv;

  // Per-string parse state.
  phase_t             phase_r,  phase_nxt;
  logic               neg_r,    neg_nxt;
  logic [BASE_W-1:0]  wb_r,     wb_nxt;
  logic [VALUE_W-1:0] acc_r,    acc_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;
  logic               stop_r,   stop_nxt;
  logic               step_done;
  logic               step_take;
  logic [WGT_W-1:0]   step_wgt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic               out_bad_r,   out_bad_nxt;
  logic               res_bad;

  // The input stage moves on unless a last beat would overwrite a held result.
  assign s1_adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // Configuration write and input stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r <= BASE_RESET;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_base_r <= cfg_wr_data;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.char_byte;
      s1_last_r <= in_ch.last_char;
    end
  end

  // One byte of the parse: whitespace, sign, radix prefix, then digits.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    wb_nxt    = wb_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    stop_nxt  = stop_r;
    step_done = 1'b0;
    step_take = 1'b0;
    step_wgt  = digit_weight(s1_byte_r);

    // The radix is latched at the first byte of a string.
    if (phase_r == PH_SPACE && cnt_r == '0 && !stop_r) begin
      wb_nxt = cfg_base_r;
      if (cfg_base_r > BASE_MAX) begin
        stop_nxt = 1'b1;
      end
    end

    if (!stop_nxt) begin
      if (phase_nxt == PH_SPACE) begin
        if (is_blank(s1_byte_r)) begin
          step_take = 1'b1;
          step_done = 1'b1;
        end else begin
          phase_nxt = PH_SIGNED;
          if (s1_byte_r == CHAR_MINUS) begin
            neg_nxt   = 1'b1;
            step_take = 1'b1;
            step_done = 1'b1;
          end else if (s1_byte_r == CHAR_PLUS) begin
            step_take = 1'b1;
            step_done = 1'b1;
          end
        end
      end
      if (!step_done && phase_nxt == PH_SIGNED) begin
        if ((wb_nxt == BASE_AUTO || wb_nxt == BASE_HEX) && s1_byte_r == CHAR_0) begin
          if (wb_nxt == BASE_AUTO) begin
            wb_nxt = BASE_OCT;
          end
          phase_nxt = PH_ZERO;
          step_take = 1'b1;
          step_done = 1'b1;
        end else begin
          if (wb_nxt == BASE_AUTO) begin
            wb_nxt = BASE_DEC;
          end
          phase_nxt = PH_DIGITS;
        end
      end
      if (!step_done && phase_nxt == PH_ZERO) begin
        phase_nxt = PH_DIGITS;
        if (s1_byte_r == CHAR_LX || s1_byte_r == CHAR_UX) begin
          wb_nxt    = BASE_HEX;
          step_take = 1'b1;
          step_done = 1'b1;
        end
      end
      // Digits accumulate as a negative number with wraparound.
      if (!step_done) begin
        if (step_wgt < {1'b0, wb_nxt}) begin
          acc_nxt   = VALUE_W'(acc_r * wb_nxt) - VALUE_W'(step_wgt);
          step_take = 1'b1;
        end else begin
          stop_nxt = 1'b1;
        end
      end
    end

    if (step_take && cnt_r < COUNT_CAP) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    // Result of a finished string.
    res_bad       = wb_nxt > BASE_MAX;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_bad_nxt   = out_bad_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
      out_bad_nxt   = res_bad;
      out_value_nxt = res_bad ? '0 : (neg_nxt ? acc_nxt : (~acc_nxt + 1'b1));
      out_count_nxt = res_bad ? '0 : cnt_nxt;
      phase_nxt     = PH_SPACE;
      neg_nxt       = 1'b0;
      wb_nxt        = BASE_AUTO;
      acc_nxt       = '0;
      cnt_nxt       = '0;
      stop_nxt      = 1'b0;
    end
  end

  // Parse state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SPACE;
      neg_r       <= 1'b0;
      wb_r        <= BASE_AUTO;
      acc_r       <= '0;
      cnt_r       <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        wb_r    <= wb_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        stop_r  <= stop_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.parsed_value   = out_value_r;
  assign out_ch.bytes_consumed = out_count_r;
  assign out_ch.bad_base       = out_bad_r;

  // An invalid radix reports zero value and zero count.
  `STIP_ASSERT_SAME(a_bad_base_zero, out_valid_r && out_bad_r, out_value_r == '0 && out_count_r == '0)
  // A finished string leaves the parse state cleared for the next one.
  `STIP_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_last_r, phase_r == PH_SPACE && cnt_r == '0 && !stop_r && acc_r == '0)
  // The input stage only stalls behind a held result.
  `STIP_ASSERT_SAME(a_stall_cause, !in_ch.ready, out_valid_r && !out_ch.ready && s1_last_r)
  // A stalled input beat is neither lost nor altered.
  `STIP_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
  // The consumed count never passes its limit.
  `STIP_ASSERT_SAME(a_count_cap, 1'b1, cnt_r <= COUNT_CAP)

endmodule

// ----- tb/sv/tb_string_to_integer_parser.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// String-to-integer parser testbench
// Streams character strings into the parser under several radix settings and
// compares every result beat against a parse computed here, byte by byte.
// ---------------------------------------------------------------------------
module tb_string_to_integer_parser;
  import stip_pkg::*;

  // Saturation limit of the consumed count for the default parameter.
  localparam longint unsigned COUNT_CAP =
      (MAX_CONSUMED_DEF < 64'd65535) ? MAX_CONSUMED_DEF : 64'd65535;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          count;
    logic                      bad;
  } parse_result_t;

  // Tracks the parse of the string in flight and holds the results it owes.
  class strtol_scoreboard;
    logic [BASE_W-1:0]  radix_reg;
    phase_t             phase;
    bit                 negative;
    logic [BASE_W-1:0]  radix;
    logic [VALUE_W-1:0] acc;
    logic [CNT_W-1:0]   count;
    bit                 halted;
    parse_result_t      pending_parses[$];
    int unsigned        mismatches;

    function new();
      radix_reg  = BASE_RESET;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      phase    = PH_SPACE;
      negative = 1'b0;
      radix    = '0;
      acc      = '0;
      count    = '0;
      halted   = 1'b0;
    endfunction

    function void set_radix(input logic [BASE_W-1:0] v);
      radix_reg = v;
    endfunction

    function void take_byte();
      if (longint'(count) < COUNT_CAP) count++;
    endfunction

    // Weight of an alphanumeric character; anything else gets NO_DIGIT.
    function logic [WGT_W-1:0] char_weight(input logic [CHAR_W-1:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return WGT_W'(c - CHAR_0);
      if (c >= CHAR_LA && c <= CHAR_LZ) return WGT_W'(c - CHAR_LA) + 7'd10;
      if (c >= CHAR_UA && c <= CHAR_UZ) return WGT_W'(c - CHAR_UA) + 7'd10;
      return NO_DIGIT;
    endfunction

    // Advances the parse by one character that has not been stopped.
    function void parse_char(input logic [CHAR_W-1:0] c);
      logic [WGT_W-1:0] w;
      if (phase == PH_SPACE) begin
        if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
          take_byte();
          return;
        end
        phase = PH_SIGNED;
        if (c == CHAR_MINUS) begin
          negative = 1'b1;
          take_byte();
          return;
        end
        if (c == CHAR_PLUS) begin
          take_byte();
          return;
        end
      end
      if (phase == PH_SIGNED) begin
        if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CHAR_0) begin
          if (radix == BASE_AUTO) radix = BASE_OCT;
          phase = PH_ZERO;
          take_byte();
          return;
        end
        if (radix == BASE_AUTO) radix = BASE_DEC;
        phase = PH_DIGITS;
      end
      if (phase == PH_ZERO) begin
        phase = PH_DIGITS;
        if (c == CHAR_LX || c == CHAR_UX) begin
          radix = BASE_HEX;
          take_byte();
          return;
        end
      end
      w = char_weight(c);
      if (w < {1'b0, radix}) begin
        acc = acc * VALUE_W'(radix) - VALUE_W'(w);
        take_byte();
      end else begin
        halted = 1'b1;
      end
    endfunction

    // Called for every accepted character beat.
    function void note_char(input logic [CHAR_W-1:0] c, input logic last);
      parse_result_t r;
      if (phase == PH_SPACE && count == '0 && !halted) begin
        radix = radix_reg;
        if (radix > BASE_MAX) halted = 1'b1;
      end
      if (!halted) parse_char(c);
      if (last) begin
        r.bad = (radix > BASE_MAX);
        if (r.bad) begin
          r.value = '0;
          r.count = '0;
        end else begin
          r.value = negative ? acc : -acc;
          r.count = count;
        end
        pending_parses.push_back(r);
        clear_string();
      end
    endfunction

    // Called for every accepted result beat.
    function void check_result(input logic signed [VALUE_W-1:0] value,
                               input logic [CNT_W-1:0] cnt, input logic bad);
      parse_result_t e;
      if (pending_parses.size() == 0) begin
        $error("result beat with no parse outstanding: value %0d count %0d",
               value, cnt);
        mismatches++;
        return;
      end
      e = pending_parses.pop_front();
      if (value !== e.value) begin
        $error("parsed_value: expected %0d, actual %0d", e.value, value);
        mismatches++;
      end
      if (cnt !== e.count) begin
        $error("bytes_consumed: expected %0d, actual %0d", e.count, cnt);
        mismatches++;
      end
      if (bad !== e.bad) begin
        $error("bad_base: expected %0d, actual %0d", e.bad, bad);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_parses.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [BASE_W-1:0] cfg_wr_data;
  bit                quiet = 1'b0;

  strtol_scoreboard sb = new();

  stip_in_if  in_ch();
  stip_out_if out_ch();

  string_to_integer_parser uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Free-running clock, 20 ns period.
  always #10 clk = ~clk;

  // Beats are taken at the rising edge on both channels.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_char(in_ch.char_byte, in_ch.last_char);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.parsed_value, out_ch.bytes_consumed, out_ch.bad_base);
    end
  end

  // Result-side back-pressure in random bursts, none once the run goes quiet.
  initial begin : result_ready_drive
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall = $urandom_range(1, 18) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Drives one character beat, sometimes after an idle burst.
  task automatic send_beat(input logic [CHAR_W-1:0] c, input logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= c;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_string(input char_q_t s);
    foreach (s[i]) send_beat(s[i], i == s.size() - 1);
  endtask

  // Lets every owed result arrive, then gives the pipeline time to settle.
  task automatic wait_parses_done();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_radix(input logic [BASE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sb.set_radix(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic char_q_t text_bytes(input string t);
    char_q_t q;
    for (int i = 0; i < t.len(); i++) q.push_back(t[i]);
    return q;
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(CHAR_TAB, CHAR_CR + 1));
    if (c > CHAR_CR) c = CHAR_SPACE;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned w);
    if (w < 10) return CHAR_0 + CHAR_W'(w);
    if ($urandom_range(0, 1) != 0) return CHAR_LA + CHAR_W'(w - 10);
    return CHAR_UA + CHAR_W'(w - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] x_char();
    return ($urandom_range(0, 1) != 0) ? CHAR_LX : CHAR_UX;
  endfunction

  // Mostly well-formed numbers in the given radix, the rest raw noise.
  function automatic char_q_t make_string(input logic [BASE_W-1:0] b);
    char_q_t     q;
    int unsigned kind;
    int unsigned eff;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      repeat ($urandom_range(1, 8)) q.push_back(CHAR_W'($urandom_range(0, 255)));
      return q;
    end
    repeat ($urandom_range(0, 3)) q.push_back(blank_char());
    case ($urandom_range(0, 3))
      0: q.push_back(CHAR_MINUS);
      1: q.push_back(CHAR_PLUS);
      default: ;
    endcase
    eff = (b > BASE_MAX) ? BASE_MAX : b;
    if (b == BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          q.push_back(CHAR_0);
          q.push_back(x_char());
          eff = BASE_HEX;
        end
        1: begin
          q.push_back(CHAR_0);
          eff = BASE_OCT;
        end
        default: begin
          q.push_back(digit_char($urandom_range(1, 9)));
          eff = BASE_DEC;
        end
      endcase
    end else if (b == BASE_HEX && $urandom_range(0, 1) != 0) begin
      q.push_back(CHAR_0);
      q.push_back(x_char());
    end
    repeat ($urandom_range(0, 24)) q.push_back(digit_char($urandom_range(0, eff - 1)));
    if (kind < 5) begin
      repeat ($urandom_range(1, 3)) q.push_back(CHAR_W'($urandom_range(0, 255)));
    end
    if (q.size() == 0) q.push_back(CHAR_W'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic logic [BASE_W-1:0] pick_radix();
    case ($urandom_range(0, 9))
      0: return BASE_AUTO;
      1: return BASE_W'(1);
      2: return BASE_W'(2);
      3: return BASE_OCT;
      4: return BASE_DEC;
      5: return BASE_HEX;
      6: return BASE_MAX;
      7: return BASE_MAX + BASE_W'(1);
      8: return {BASE_W{1'b1}};
      default: return BASE_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Hard stop in case the block hangs.
  initial begin
    #120_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    char_q_t           s;
    logic [BASE_W-1:0] b;
    int unsigned       sent;
    in_ch.valid     = 1'b0;
    in_ch.char_byte = '0;
    in_ch.last_char = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset radix: blanks, sign and a stop byte, a lone sign, zero and high bytes.
    send_string(text_bytes(" \t-42!"));
    send_string(text_bytes("+"));
    s = {};
    s.push_back(8'h00);
    send_string(s);
    s = {};
    s.push_back(8'hFF);
    send_string(s);
    wait_parses_done();

    // Auto-detect: hex prefix, octal lead and a prefix with no digits after it.
    write_radix(BASE_AUTO);
    send_string(text_bytes("0x1F"));
    send_string(text_bytes("017"));
    send_string(text_bytes("-0X"));
    wait_parses_done();

    write_radix(BASE_HEX);
    send_string(text_bytes("0xfF"));
    wait_parses_done();

    write_radix(BASE_MAX);
    send_string(text_bytes("zZ"));
    wait_parses_done();

    // A radix past the top stops the string at once.
    write_radix({BASE_W{1'b1}});
    send_string(text_bytes("5"));
    wait_parses_done();

    // Random phases, each under a fresh radix; the tail runs without idling.
    sent = 0;
    while (sent < 1300) begin
      quiet = (sent >= 1100);
      b = pick_radix();
      write_radix(b);
      repeat ($urandom_range(4, 12)) begin
        s = make_string(b);
        send_string(s);
        sent += s.size();
      end
      wait_parses_done();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/stip_pkg.sv
rtl/core/stip_if.sv
rtl/core/string_to_integer_parser.sv
tb/sv/tb_string_to_integer_parser.sv
